/* rtl/core/fotsr_pkg.sv */
// shared types and constants of the file offset to sector run mapper
package fotsr_pkg;

  localparam int MAX_EXTENTS         = 64;
  localparam int ENTRY_W             = 6;
  localparam int CLUS_W              = 28;
  localparam int IDX_W               = 24;
  localparam int CLUST_W             = 29;
  localparam int SECT_W              = 7;
  localparam int REM_W               = 6;
  localparam int MAX_REQUEST_SECTORS = 63;
  localparam int FIRST_DATA_CLUSTER  = 2;
  localparam int CHUNK_MAX           = 64;
  localparam int CHUNK_RESET         = 64;

  localparam logic       KIND_LOAD = 1'b0;
  localparam logic       KIND_READ = 1'b1;

  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [1:0] CFG_CLUSTER_SHIFT = 2'd0;
  localparam logic [1:0] CFG_DATA_BASE_LBA = 2'd1;
  localparam logic [1:0] CFG_CHUNK_SECTORS = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [5:0]        entry_index;
    logic [27:0]       extent_clusters;
    logic [27:0]       extent_first_cluster;
    logic [31:0]       byte_offset;
    logic [14:0]       byte_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [31:0]       block_address;
    logic [6:0]        sectors;
    logic              last;
  } out_item_t;

  // table write from a load transfer
  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] idx;
    logic [CLUS_W-1:0]  clusters;
    logic [CLUS_W-1:0]  first;
  } wr_t;

  // lookup token moving down the chain
  typedef struct packed {
    logic             active;
    logic [IDX_W-1:0] rest;
  } tok_t;

  // lookup resolution, zero from cells that do not resolve
  typedef struct packed {
    logic               valid;
    logic               fail;
    logic [CLUST_W-1:0] clust;
    logic [CLUS_W-1:0]  left;
  } hit_t;

endpackage

/* rtl/core/fotsr_cell.sv */
// one extent table cell of the lookup chain
module fotsr_cell
  import fotsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ENTRY_W-1:0] cell_idx,
  input  wr_t                wr,
  input  tok_t               tok_in,
  output tok_t               tok_out,
  output hit_t               hit
);

  logic [CLUS_W-1:0] len_r;
  logic [CLUS_W-1:0] start_r;
  tok_t              tok_r;
  logic              empty;
  logic              inside_ext;
  logic              resolve;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
      if (wr.en && wr.idx == cell_idx) begin
        len_r <= wr.clusters;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == cell_idx) begin
      start_r <= wr.first;
    end
  end

  assign empty      = (len_r == '0);
  assign inside_ext = ({{(CLUS_W-IDX_W){1'b0}}, tok_r.rest} < len_r);
  assign resolve    = tok_r.active && (empty || inside_ext);

  assign tok_out.active = tok_r.active && !resolve;
  assign tok_out.rest   = tok_r.rest - len_r[IDX_W-1:0];

  always_comb begin
    hit = '0;
    if (resolve) begin
      hit.valid = 1'b1;
      hit.fail  = empty;
      hit.clust = CLUST_W'(start_r) + CLUST_W'(tok_r.rest);
      hit.left  = len_r - CLUS_W'(tok_r.rest);
    end
  end

endmodule

/* rtl/core/fotsr_ctrl.sv */
// request sequencer, configuration registers and result register
module fotsr_ctrl
  import fotsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output wr_t       wr,
  output tok_t      inject,
  input  hit_t      hit
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_ADDR = 3'd3;
  localparam logic [2:0] S_CMD  = 3'd4;
  localparam logic [2:0] S_STAT = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [2:0]         shift_r;
  logic [31:0]        base_r;
  logic [SECT_W-1:0]  chunk_r;

  logic [IDX_W-1:0]   foff_r, foff_nxt;
  logic [REM_W-1:0]   remain_r, remain_nxt;
  logic [CLUST_W-1:0] clust_r, clust_nxt;
  logic [CLUS_W-1:0]  left_r, left_nxt;
  logic [31:0]        lba_r, lba_nxt;
  logic [SECT_W-1:0]  run_r, run_nxt;
  logic [1:0]         stat_r, stat_nxt;

  logic               out_valid_r;
  out_item_t          out_data_r;
  logic               out_free;
  logic               emit;
  out_item_t          emit_item;

  logic               in_fire;
  logic               misaligned;
  logic               oversized;
  logic [SECT_W-1:0]  chunk_eff;
  logic [IDX_W-1:0]   in_clust;
  logic [CLUST_W-1:0] clust_rel;
  logic [31:0]        clust_off;
  logic [34:0]        run_full;
  logic [SECT_W-1:0]  n_cmd;
  logic [SECT_W-1:0]  remain_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign wr.en       = in_fire && in_data.kind == KIND_LOAD;
  assign wr.idx      = in_data.entry_index;
  assign wr.clusters = in_data.extent_clusters;
  assign wr.first    = in_data.extent_first_cluster;

  assign inject.active = (state_r == S_LOOK);
  assign inject.rest   = foff_r >> shift_r;

  assign misaligned = (|in_data.byte_offset[8:0]) || (|in_data.byte_length[8:0]);
  assign oversized  = SECT_W'(in_data.byte_length[14:9]) > SECT_W'(MAX_REQUEST_SECTORS);

  always_comb begin
    priority if (chunk_r == '0) begin
      chunk_eff = SECT_W'(1);
    end else if (chunk_r > SECT_W'(CHUNK_MAX)) begin
      chunk_eff = SECT_W'(CHUNK_MAX);
    end else begin
      chunk_eff = chunk_r;
    end
  end

  assign in_clust  = foff_r & ~({IDX_W{1'b1}} << shift_r);
  assign clust_rel = clust_r - CLUST_W'(FIRST_DATA_CLUSTER);
  assign clust_off = 32'(clust_rel) << shift_r;
  assign run_full  = (35'(left_r) << shift_r) - 35'(in_clust);
  assign remain_ext = SECT_W'(remain_r);

  always_comb begin
    n_cmd = run_r;
    if (remain_ext < n_cmd) n_cmd = remain_ext;
    if (chunk_eff < n_cmd) n_cmd = chunk_eff;
  end

  always_comb begin
    state_nxt  = state_r;
    foff_nxt   = foff_r;
    remain_nxt = remain_r;
    clust_nxt  = clust_r;
    left_nxt   = left_r;
    lba_nxt    = lba_r;
    run_nxt    = run_r;
    stat_nxt   = stat_r;
    emit       = 1'b0;
    emit_item  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.kind == KIND_READ) begin
          foff_nxt   = IDX_W'(in_data.byte_offset[31:9]);
          remain_nxt = in_data.byte_length[14:9];
          priority if (misaligned || oversized) begin
            stat_nxt  = KIND_FAIL;
            state_nxt = S_STAT;
          end else if (in_data.byte_length[14:9] == '0) begin
            stat_nxt  = KIND_DONE;
            state_nxt = S_STAT;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (hit.valid) begin
          clust_nxt = hit.clust;
          left_nxt  = hit.left;
          if (hit.fail || hit.clust < CLUST_W'(FIRST_DATA_CLUSTER)) begin
            stat_nxt  = KIND_FAIL;
            state_nxt = S_STAT;
          end else begin
            state_nxt = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        lba_nxt   = base_r + clust_off + 32'(in_clust);
        run_nxt   = (run_full > 35'(CHUNK_MAX)) ? SECT_W'(CHUNK_MAX) : run_full[SECT_W-1:0];
        state_nxt = S_CMD;
      end
      S_CMD: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_item.result_kind   = KIND_CMD;
          emit_item.block_address = lba_r;
          emit_item.sectors       = n_cmd;
          lba_nxt    = lba_r + 32'(n_cmd);
          foff_nxt   = foff_r + IDX_W'(n_cmd);
          run_nxt    = run_r - n_cmd;
          remain_nxt = REM_W'(remain_ext - n_cmd);
          priority if (remain_ext == n_cmd) begin
            stat_nxt  = KIND_DONE;
            state_nxt = S_STAT;
          end else if (run_r == n_cmd) begin
            state_nxt = S_LOOK;
          end else begin
            state_nxt = S_CMD;
          end
        end
      end
      S_STAT: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_item.result_kind = stat_r;
          emit_item.last        = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      shift_r     <= '0;
      base_r      <= '0;
      chunk_r     <= SECT_W'(CHUNK_RESET);
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CLUSTER_SHIFT: shift_r <= cfg_data[2:0];
          CFG_DATA_BASE_LBA: base_r  <= cfg_data;
          CFG_CHUNK_SECTORS: chunk_r <= cfg_data[SECT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    foff_r   <= foff_nxt;
    remain_r <= remain_nxt;
    clust_r  <= clust_nxt;
    left_r   <= left_nxt;
    lba_r    <= lba_nxt;
    run_r    <= run_nxt;
    stat_r   <= stat_nxt;
    if (emit) begin
      out_data_r <= emit_item;
    end
  end

endmodule

/* rtl/core/file_offset_to_sector_run_mapper.sv */
// top level of the file offset to sector run mapper
//
// in_*: one transfer per item. a load item writes one extent table slot and
// ends in the transfer cycle. a read item is mapped to sector read commands
// (result_kind 0) followed by one status (done or failed, last set).
// out_*: one transfer per result; a registered output stage holds it while
// the receiver stalls, and the sequencer waits with the next result.
// cfg_*: register writes, always ready; write only between requests.
// lookup: a read walks a chain of 64 extent cells. the sequencer injects a token
// that passes registered from cell to cell until one resolves it; each run then
// takes an address step and a command step per command, issued while the
// receiver is ready. one read is in flight at a time; the next item is taken
// once its status is in the output stage.
// reset: table empty, cluster_shift 0, data_base_lba 0, chunk_sectors 64.
module file_offset_to_sector_run_mapper
  import fotsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  wr_t  wr;
  tok_t tok [MAX_EXTENTS+1];
  hit_t hits [MAX_EXTENTS];
  hit_t hit_any;

  fotsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .inject    (tok[0]),
    .hit       (hit_any)
  );

  for (genvar e = 0; e < MAX_EXTENTS; e++) begin : g_cell
    fotsr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (ENTRY_W'(e)),
      .wr       (wr),
      .tok_in   (tok[e]),
      .tok_out  (tok[e+1]),
      .hit      (hits[e])
    );
  end

  // a token leaving the last cell ran past the table end
  always_comb begin
    hit_any       = '0;
    hit_any.valid = tok[MAX_EXTENTS].active;
    hit_any.fail  = tok[MAX_EXTENTS].active;
    for (int e = 0; e < MAX_EXTENTS; e++) begin
      hit_any = hit_any | hits[e];
    end
  end

endmodule
